// ===== sv/spectral_derivative_coefficient_assert.svh =====
// Assertion macros for the spectral derivative coefficient block.
// SDC_ASSERT_IMPL: same-cycle implication. SDC_ASSERT_NEXT: next-cycle implication.
`ifndef SPECTRAL_DERIVATIVE_COEFFICIENT_ASSERT_SVH
`define SPECTRAL_DERIVATIVE_COEFFICIENT_ASSERT_SVH

`ifndef SYNTH
`define SDC_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sdc: implication check failed");
`define SDC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sdc: next-cycle check failed");
`else
`define SDC_ASSERT_IMPL(name, clk, rst_n, ante, cons)
`define SDC_ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif

`endif

// ===== sv/sdc_pkg.sv =====
`timescale 1ns / 1ps

package sdc_pkg;

    localparam int IDX_W   = 12;
    localparam int SIZE_W  = 13;
    localparam int ORD_W   = 3;
    localparam int TOT_W   = 4;
    localparam int STEP_W  = 32;
    localparam int BASE_W  = 44;   // step * |f|, exact
    localparam int MAG_W   = 63;   // unsigned magnitude below 2^63
    localparam int COEF_W  = 64;
    localparam int PROD_W  = 107;  // MAG_W + BASE_W
    localparam int CFG_AW  = 3;

    localparam logic [ORD_W-1:0]  ORDER_X_RST = 3'd1;
    localparam logic [ORD_W-1:0]  ORDER_Y_RST = 3'd0;
    localparam logic [SIZE_W-1:0] SIZE_RST    = 13'd256;
    localparam logic [STEP_W-1:0] STEP_RST    = 32'd16777216;

    localparam logic [COEF_W-1:0] SAT_POS = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic [COEF_W-1:0] SAT_NEG = {1'b1, {(COEF_W-1){1'b0}}};

    typedef enum logic [CFG_AW-1:0] {
        CFG_ORDER_X  = 3'd0,
        CFG_ORDER_Y  = 3'd1,
        CFG_ROWS     = 3'd2,
        CFG_COLS     = 3'd3,
        CFG_ROW_STEP = 3'd4,
        CFG_COL_STEP = 3'd5
    } t_cfg_addr;

    typedef struct packed {
        logic kill;     // result is all zero
        logic origin;   // origin bin with total order zero
        logic neg;      // magnitude is negated
        logic imag;     // magnitude goes to the imaginary part
    } t_flags;

    typedef struct packed {
        logic [IDX_W-1:0] f;
        logic             zero;
        logic             flip;
    } t_axis;

    typedef struct packed {
        t_flags           flags;
        logic [IDX_W-1:0] fx;
        logic [IDX_W-1:0] fy;
    } t_s1;

    typedef struct packed {
        t_flags            flags;
        logic [BASE_W-1:0] bx;
        logic [BASE_W-1:0] by;
    } t_s2;

    typedef struct packed {
        t_flags            flags;
        logic              sat;
        logic [BASE_W-1:0] bx;
        logic [BASE_W-1:0] by;
        logic [63:0]       p00;
        logic [43:0]       p01;
        logic [62:0]       p10;
        logic [42:0]       p11;
    } t_part;

    typedef struct packed {
        t_flags            flags;
        logic              sat;
        logic [BASE_W-1:0] bx;
        logic [BASE_W-1:0] by;
        logic [MAG_W-1:0]  mag;
    } t_mag;

    // Signed frequency of one axis, zero-factor and sign-flip flags.
    function automatic t_axis axis_eval(
        input logic [IDX_W-1:0]  idx,
        input logic [SIZE_W-1:0] size,
        input logic [ORD_W-1:0]  d,
        input logic [STEP_W-1:0] step
    );
        t_axis            a;
        logic [IDX_W-1:0] half;
        logic             neg;
        a    = '0;
        half = size[SIZE_W-1:1];
        neg  = 1'b0;
        if (d != '0) begin
            if (idx < half) begin
                a.f = idx;
            end else if (idx == half) begin
                a.f = half;
                if (d[0]) begin
                    a.zero = 1'b1;
                end
            end else begin
                a.f = IDX_W'(size - {1'b0, idx});
                neg = 1'b1;
            end
            if (a.f == '0 || step == '0) begin
                a.zero = 1'b1;
            end
            a.flip = neg & d[0];
        end
        return a;
    endfunction

endpackage

// ===== sv/spectral_derivative_coefficient.sv =====
`timescale 1ns / 1ps
// Spectral derivative coefficient for one 2-D FFT bin.
// Input stream: i_s_tdata carries (row_index, col_index); one request per bin.
// Output stream: o_m_tdata carries (coef_real, coef_imag) in signed Q39.24 with
// FRAC_BITS fraction bits, o_m_tuser the overflow flag (part saturated).
// Configuration: write i_cfg_data to register i_cfg_addr with i_cfg_we high;
// index 0 order_x, 1 order_y, 2 rows_in_use, 3 cols_in_use, 4 row step,
// 5 column step. Write only while the pipeline is empty.
// Throughput: one bin per clock while i_m_tready stays high. Each bin passes
// stage 1, stage 2, the magnitude chain and the output register. The chain
// holds up to 2*MAX_ORDER rounded products in series, each split into four
// partial products (32x32 bits at most) in one stage, summed in the next.
// Every stage has its own valid bit and loads when the stage after it is
// empty or moving, so bubbles close up and a stalled receiver fills the
// pipeline before o_s_tready drops; nothing is lost or repeated.
// Reset (synchronous, i_rst_n low) empties the pipeline and restores the
// register defaults: order_x 1, order_y 0, sizes 256, steps 1.0.
module spectral_derivative_coefficient #(
    parameter int MAX_SIZE  = 4096,
    parameter int MAX_ORDER = 4,
    parameter int FRAC_BITS = 24
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_addr,
    input  logic [31:0]  i_cfg_data,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [23:0]  i_s_tdata,    // [11:0] row_index, [23:12] col_index
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    output logic [127:0] o_m_tdata,    // [63:0] coef_real, [127:64] coef_imag
    output logic         o_m_tuser     // [0] overflow
);

    localparam int NSTEP = 2 * MAX_ORDER;
    localparam logic [sdc_pkg::COEF_W-1:0] ONE_C = sdc_pkg::COEF_W'(1) << FRAC_BITS;
    localparam logic [sdc_pkg::BASE_W-1:0] ONE_B = sdc_pkg::BASE_W'(1) << FRAC_BITS;
    localparam logic [sdc_pkg::PROD_W-1:0] RND   = sdc_pkg::PROD_W'(1) << (FRAC_BITS - 1);

    // ---------------- configuration registers ----------------
    logic [sdc_pkg::ORD_W-1:0]  r_order_x, r_order_y;
    logic [sdc_pkg::SIZE_W-1:0] r_rows, r_cols;
    logic [sdc_pkg::STEP_W-1:0] r_row_step, r_col_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order_x  <= sdc_pkg::ORDER_X_RST;
            r_order_y  <= sdc_pkg::ORDER_Y_RST;
            r_rows     <= sdc_pkg::SIZE_RST;
            r_cols     <= sdc_pkg::SIZE_RST;
            r_row_step <= sdc_pkg::STEP_RST;
            r_col_step <= sdc_pkg::STEP_RST;
        end else if (i_cfg_we) begin
            case (sdc_pkg::t_cfg_addr'(i_cfg_addr))
                sdc_pkg::CFG_ORDER_X:  r_order_x  <= i_cfg_data[sdc_pkg::ORD_W-1:0];
                sdc_pkg::CFG_ORDER_Y:  r_order_y  <= i_cfg_data[sdc_pkg::ORD_W-1:0];
                sdc_pkg::CFG_ROWS:     r_rows     <= i_cfg_data[sdc_pkg::SIZE_W-1:0];
                sdc_pkg::CFG_COLS:     r_cols     <= i_cfg_data[sdc_pkg::SIZE_W-1:0];
                sdc_pkg::CFG_ROW_STEP: r_row_step <= i_cfg_data;
                sdc_pkg::CFG_COL_STEP: r_col_step <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Effective sizes (even, 2..MAX_SIZE) and orders (at most MAX_ORDER).
    function automatic logic [sdc_pkg::SIZE_W-1:0] fix_size(
        input logic [sdc_pkg::SIZE_W-1:0] s
    );
        logic [sdc_pkg::SIZE_W-1:0] e;
        e = {s[sdc_pkg::SIZE_W-1:1], 1'b0};
        if (e < sdc_pkg::SIZE_W'(2)) begin
            e = sdc_pkg::SIZE_W'(2);
        end else if ({4'b0, e} > 17'(MAX_SIZE)) begin
            e = sdc_pkg::SIZE_W'(MAX_SIZE);
        end
        return e;
    endfunction

    function automatic logic [sdc_pkg::ORD_W-1:0] fix_order(
        input logic [sdc_pkg::ORD_W-1:0] d
    );
        logic [sdc_pkg::ORD_W-1:0] o;
        o = d;
        if ({1'b0, d} > 4'(MAX_ORDER)) begin
            o = sdc_pkg::ORD_W'(MAX_ORDER);
        end
        return o;
    endfunction

    logic [sdc_pkg::SIZE_W-1:0] w_nr, w_nc;
    logic [sdc_pkg::ORD_W-1:0]  w_dx, w_dy;
    logic [sdc_pkg::TOT_W-1:0]  w_dxe, w_tot;

    assign w_nr  = fix_size(r_rows);
    assign w_nc  = fix_size(r_cols);
    assign w_dx  = fix_order(r_order_x);
    assign w_dy  = fix_order(r_order_y);
    assign w_dxe = {1'b0, w_dx};
    assign w_tot = {1'b0, w_dx} + {1'b0, w_dy};

    // ---------------- stage ready chain ----------------
    logic             r_v1, r_v2, r_vo;
    logic [NSTEP-1:0] r_va, r_vb;
    logic             w_rdy1, w_rdy2, w_rdyo;
    logic [NSTEP-1:0] w_rdya, w_rdyb;

    assign w_rdyo = !r_vo || i_m_tready;
    assign w_rdy2 = !r_v2 || w_rdya[0];
    assign w_rdy1 = !r_v1 || w_rdy2;
    assign o_s_tready = w_rdy1;

    // ---------------- stage 1: frequency analysis ----------------
    sdc_pkg::t_s1   r_s1, n_s1;
    sdc_pkg::t_axis w_ax, w_ay;
    logic [sdc_pkg::IDX_W-1:0] w_r, w_c;

    assign w_r  = i_s_tdata[11:0];
    assign w_c  = i_s_tdata[23:12];
    assign w_ax = sdc_pkg::axis_eval(w_r, w_nr, w_dx, r_row_step);
    assign w_ay = sdc_pkg::axis_eval(w_c, w_nc, w_dy, r_col_step);

    always_comb begin
        n_s1              = '0;
        n_s1.fx           = w_ax.f;
        n_s1.fy           = w_ay.f;
        n_s1.flags.origin = (w_r == '0) && (w_c == '0) && (w_tot == '0);
        n_s1.flags.kill   = ({1'b0, w_r} >= w_nr) || ({1'b0, w_c} >= w_nc)
                            || w_ax.zero || w_ay.zero;
        n_s1.flags.imag   = w_tot[0];
        // total order 2 or 3 mod 4 is negative, each odd negative axis flips
        n_s1.flags.neg    = w_tot[1] ^ w_ax.flip ^ w_ay.flip;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_rdy1) begin
            r_v1 <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy1 && i_s_tvalid) begin
            r_s1 <= n_s1;
        end
    end

    // ---------------- stage 2: axis bases ----------------
    sdc_pkg::t_s2 r_s2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_rdy2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy2 && r_v1) begin
            r_s2.flags <= r_s1.flags;
            r_s2.bx    <= sdc_pkg::BASE_W'(r_row_step) * sdc_pkg::BASE_W'(r_s1.fx);
            r_s2.by    <= sdc_pkg::BASE_W'(r_col_step) * sdc_pkg::BASE_W'(r_s1.fy);
        end
    end

    // ---------------- magnitude chain ----------------
    sdc_pkg::t_part r_pa [NSTEP];
    sdc_pkg::t_mag  r_pb [NSTEP];
    sdc_pkg::t_mag  w_src [NSTEP];
    logic [NSTEP-1:0] w_src_v;

    for (genvar k = 0; k < NSTEP; k++) begin : g_step
        logic [sdc_pkg::BASE_W-1:0] w_fac;
        logic [sdc_pkg::PROD_W-1:0] w_sum;
        logic [sdc_pkg::PROD_W-1:0] w_hi;

        if (k == 0) begin : g_first
            always_comb begin
                w_src[k]       = '0;
                w_src[k].flags = r_s2.flags;
                w_src[k].bx    = r_s2.bx;
                w_src[k].by    = r_s2.by;
                w_src[k].mag   = sdc_pkg::MAG_W'(ONE_C);
            end
            assign w_src_v[k] = r_v2;
        end else begin : g_next
            assign w_src[k]   = r_pb[k-1];
            assign w_src_v[k] = r_vb[k-1];
        end

        if (k == NSTEP - 1) begin : g_last
            assign w_rdyb[k] = !r_vb[k] || w_rdyo;
        end else begin : g_mid
            assign w_rdyb[k] = !r_vb[k] || w_rdya[k+1];
        end
        assign w_rdya[k] = !r_va[k] || w_rdyb[k];

        // step k multiplies by the row base, then the column base, else 1.0
        always_comb begin
            if (sdc_pkg::TOT_W'(k) < w_dxe) begin
                w_fac = w_src[k].bx;
            end else if (sdc_pkg::TOT_W'(k) < w_tot) begin
                w_fac = w_src[k].by;
            end else begin
                w_fac = ONE_B;
            end
        end

        // partial products
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_va[k] <= 1'b0;
            end else if (w_rdya[k]) begin
                r_va[k] <= w_src_v[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdya[k] && w_src_v[k]) begin
                r_pa[k].flags <= w_src[k].flags;
                r_pa[k].sat   <= w_src[k].sat;
                r_pa[k].bx    <= w_src[k].bx;
                r_pa[k].by    <= w_src[k].by;
                r_pa[k].p00   <= w_src[k].mag[31:0] * w_fac[31:0];
                r_pa[k].p01   <= 44'(w_src[k].mag[31:0]) * 44'(w_fac[43:32]);
                r_pa[k].p10   <= 63'(w_src[k].mag[62:32]) * 63'(w_fac[31:0]);
                r_pa[k].p11   <= 43'(w_src[k].mag[62:32]) * 43'(w_fac[43:32]);
            end
        end

        // sum, round half up, saturation
        assign w_sum = (sdc_pkg::PROD_W'(r_pa[k].p11) << 64)
                     + (sdc_pkg::PROD_W'(r_pa[k].p01) << 32)
                     + (sdc_pkg::PROD_W'(r_pa[k].p10) << 32)
                     + sdc_pkg::PROD_W'(r_pa[k].p00) + RND;
        assign w_hi  = w_sum >> (FRAC_BITS + sdc_pkg::MAG_W);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vb[k] <= 1'b0;
            end else if (w_rdyb[k]) begin
                r_vb[k] <= r_va[k];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_rdyb[k] && r_va[k]) begin
                r_pb[k].flags <= r_pa[k].flags;
                r_pb[k].sat   <= r_pa[k].sat || (w_hi != '0);
                r_pb[k].bx    <= r_pa[k].bx;
                r_pb[k].by    <= r_pa[k].by;
                r_pb[k].mag   <= w_sum[FRAC_BITS +: sdc_pkg::MAG_W];
            end
        end
    end

    // ---------------- output register ----------------
    sdc_pkg::t_mag               w_fin;
    logic [sdc_pkg::COEF_W-1:0]  w_val, n_re, n_im;
    logic                        n_ovf;
    logic [sdc_pkg::COEF_W-1:0]  r_re, r_im;
    logic                        r_ovf;

    assign w_fin = r_pb[NSTEP-1];

    always_comb begin
        if (w_fin.sat) begin
            w_val = w_fin.flags.neg ? sdc_pkg::SAT_NEG : sdc_pkg::SAT_POS;
        end else if (w_fin.flags.neg) begin
            w_val = -{1'b0, w_fin.mag};
        end else begin
            w_val = {1'b0, w_fin.mag};
        end
        n_re  = '0;
        n_im  = '0;
        n_ovf = 1'b0;
        if (w_fin.flags.kill) begin
            n_ovf = 1'b0;
        end else if (w_fin.flags.origin) begin
            n_re = ONE_C;
            n_im = ONE_C;
        end else begin
            n_ovf = w_fin.sat;
            if (w_fin.flags.imag) begin
                n_im = w_val;
            end else begin
                n_re = w_val;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else if (w_rdyo) begin
            r_vo <= r_vb[NSTEP-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdyo && r_vb[NSTEP-1]) begin
            r_re  <= n_re;
            r_im  <= n_im;
            r_ovf <= n_ovf;
        end
    end

    assign o_m_tvalid = r_vo;
    assign o_m_tdata  = {r_im, r_re};
    assign o_m_tuser  = r_ovf;

    // ---------------- checks ----------------
`include "spectral_derivative_coefficient_assert.svh"

    // a saturated result sits in one part at a full-scale value
    `SDC_ASSERT_IMPL(a_ovf_full_scale, i_clk, i_rst_n, r_vo && r_ovf,
        (r_re == sdc_pkg::SAT_POS || r_re == sdc_pkg::SAT_NEG || r_im == sdc_pkg::SAT_POS || r_im == sdc_pkg::SAT_NEG))
    // outside the origin case at most one part is nonzero
    `SDC_ASSERT_IMPL(a_one_part, i_clk, i_rst_n, r_vo,
        (r_re == '0 || r_im == '0 || (r_re == ONE_C && r_im == ONE_C)))
    // a stalled output keeps the last chain stage loaded
    `SDC_ASSERT_NEXT(a_hold_last, i_clk, i_rst_n, r_vo && !i_m_tready && r_vb[NSTEP-1],
        r_vb[NSTEP-1])

endmodule

// ===== tb/sv/tb_spectral_derivative_coefficient.sv =====
`timescale 1ns / 1ps

// Testbench for the spectral derivative coefficient block.
// Every accepted bin request is run through a local model of the multiplier
// and the expected coefficient is queued. Results are popped and checked
// field by field as they leave the master side. Register settings change
// only while the pipeline is drained.
module tb_spectral_derivative_coefficient;

    import sdc_pkg::*;

    localparam int   FRAC       = 24;
    localparam int   ORDER_CAP  = 4;
    localparam int   SIZE_CAP   = 4096;
    localparam int   WDOG_LIMIT = 3000;    // quiet cycles allowed before giving up
    localparam int   TAIL_WAIT  = 40;      // longer than a bin takes to pass the pipeline
    localparam logic [63:0] ONE_Q24 = 64'd1 << FRAC;

    // Indexes outside the register map; writes to them must be ignored.
    localparam logic [CFG_AW-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_AW-1:0] CFG_SPARE_B = 3'd7;

    typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_CYCLIC} rx_mode_t;

    // One expected coefficient, as carried on o_m_tdata / o_m_tuser.
    typedef struct packed {
        logic [63:0] re_part;
        logic [63:0] im_part;
        logic        ovf;
    } bin_coef_t;

    typedef struct {
        logic [43:0] base;
        logic        zero;
        logic        flip;
    } axis_term_t;

    // ---------------------------------------------------------------
    // DUT ports
    // ---------------------------------------------------------------
    logic         i_clk      = 1'b0;
    logic         i_rst_n    = 1'b0;
    logic         i_cfg_we   = 1'b0;
    logic [2:0]   i_cfg_addr = '0;
    logic [31:0]  i_cfg_data = '0;
    logic         i_s_tvalid = 1'b0;
    logic         o_s_tready;
    logic [23:0]  i_s_tdata  = '0;   // [11:0] row_index, [23:12] col_index
    logic         o_m_tvalid;
    logic         i_m_tready = 1'b0;
    logic [127:0] o_m_tdata;         // [63:0] coef_real, [127:64] coef_imag
    logic         o_m_tuser;         // [0] overflow

    spectral_derivative_coefficient dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------
    // Shadow of the register file, kept in step with every write
    // ---------------------------------------------------------------
    logic [2:0]  ord_x_reg;
    logic [2:0]  ord_y_reg;
    logic [12:0] rows_reg;
    logic [12:0] cols_reg;
    logic [31:0] row_step_reg;
    logic [31:0] col_step_reg;

    bin_coef_t coef_pending[$];   // expected coefficients, oldest first
    int        error_count = 0;
    int        burst_left  = 0;   // requests left in the current sender burst

    // ---------------------------------------------------------------
    // Multiplier model
    // ---------------------------------------------------------------
    // Odd sizes lose bit 0, then clamp to 2..SIZE_CAP.
    function automatic logic [12:0] legal_size(input logic [12:0] s);
        logic [12:0] t;
        t = {s[12:1], 1'b0};
        if (t < 13'd2) t = 13'd2;
        if (t > 13'(SIZE_CAP)) t = 13'(SIZE_CAP);
        return t;
    endfunction

    function automatic logic [2:0] legal_order(input logic [2:0] d);
        return (d > 3'(ORDER_CAP)) ? 3'(ORDER_CAP) : d;
    endfunction

    // Per-axis factor: |k*f| in Q.24, whether it kills the product, sign flip.
    function automatic axis_term_t axis_term(input logic [11:0] idx, input logic [12:0] n,
                                             input logic [2:0] d, input logic [31:0] step);
        axis_term_t  t;
        logic [12:0] half;
        logic [12:0] f;
        logic        neg;
        t.base = '0;
        t.zero = 1'b0;
        t.flip = 1'b0;
        neg    = 1'b0;
        half   = n >> 1;
        if (d == 3'd0) return t;
        if (idx < half) begin
            f = {1'b0, idx};
        end else if (idx == half) begin
            f = half;
            // Nyquist bin: odd order has no defined sign, so it is dropped
            if (d[0]) begin
                t.zero = 1'b1;
                return t;
            end
        end else begin
            f   = n - {1'b0, idx};
            neg = 1'b1;
        end
        if (f == '0) begin
            t.zero = 1'b1;
            return t;
        end
        t.base = 44'(step) * 44'(f);
        if (t.base == '0) begin
            t.zero = 1'b1;
            return t;
        end
        t.flip = neg & d[0];
        return t;
    endfunction

    // Q.24 product, rounded half up; ovf when it passes 2^63-1.
    function automatic logic [62:0] round_mul(input logic [62:0] a, input logic [43:0] b,
                                              output logic ovf);
        logic [127:0] p;
        p   = ({65'd0, a} * {84'd0, b}) + (128'd1 << (FRAC - 1));
        p   = p >> FRAC;
        ovf = (p > 128'h7FFF_FFFF_FFFF_FFFF);
        return p[62:0];
    endfunction

    function automatic bin_coef_t derivative_multiplier(input logic [11:0] r,
                                                        input logic [11:0] c);
        bin_coef_t   res;
        logic [12:0] nr, nc;
        logic [2:0]  dx, dy;
        axis_term_t  ax, ay;
        logic [62:0] mag;
        logic [63:0] val;
        logic [1:0]  tot;
        logic        sat, neg;
        res = '0;
        nr  = legal_size(rows_reg);
        nc  = legal_size(cols_reg);
        dx  = legal_order(ord_x_reg);
        dy  = legal_order(ord_y_reg);
        if ({1'b0, r} >= nr || {1'b0, c} >= nc) return res;
        // Origin with total order zero: both parts 1.0
        if (r == '0 && c == '0 && dx == '0 && dy == '0) begin
            res.re_part = ONE_Q24;
            res.im_part = ONE_Q24;
            return res;
        end
        ax = axis_term(r, nr, dx, row_step_reg);
        ay = axis_term(c, nc, dy, col_step_reg);
        if (ax.zero || ay.zero) return res;
        mag = 63'(ONE_Q24);
        sat = 1'b0;
        for (int k = 0; k < dx && !sat; k++) mag = round_mul(mag, ax.base, sat);
        for (int k = 0; k < dy && !sat; k++) mag = round_mul(mag, ay.base, sat);
        tot = 2'(dx + dy);                    // power of i, mod 4
        neg = tot[1] ^ ax.flip ^ ay.flip;
        if (sat) val = neg ? SAT_NEG : SAT_POS;
        else     val = neg ? (64'd0 - {1'b0, mag}) : {1'b0, mag};
        if (tot[0]) res.im_part = val;
        else        res.re_part = val;
        res.ovf = sat;
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------
    // Register write; the task returns with we low, so back-to-back writes never double-drive we.
    task automatic write_reg(input logic [CFG_AW-1:0] addr, input logic [31:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= addr;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (addr)
            CFG_ORDER_X:  ord_x_reg    = value[2:0];
            CFG_ORDER_Y:  ord_y_reg    = value[2:0];
            CFG_ROWS:     rows_reg     = value[12:0];
            CFG_COLS:     cols_reg     = value[12:0];
            CFG_ROW_STEP: row_step_reg = value;
            CFG_COL_STEP: col_step_reg = value;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic write_all_regs(input logic [2:0] ox, input logic [2:0] oy,
                                  input logic [12:0] nr, input logic [12:0] nc,
                                  input logic [31:0] kr, input logic [31:0] kc);
        write_reg(CFG_ORDER_X, 32'(ox));
        write_reg(CFG_ORDER_Y, 32'(oy));
        write_reg(CFG_ROWS, 32'(nr));
        write_reg(CFG_COLS, 32'(nc));
        write_reg(CFG_ROW_STEP, kr);
        write_reg(CFG_COL_STEP, kc);
    endtask

    // One bin request. Sender runs in bursts; a gap may open before a burst.
    // Called just after a rising edge; returns at the edge that accepted it.
    task automatic send_bin(input logic [11:0] r, input logic [11:0] c);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                i_s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {c, r};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        coef_pending.push_back(derivative_multiplier(r, c));
    endtask

    // Sender holds off until every queued coefficient has come back.
    task automatic wait_for_results();
        i_s_tvalid <= 1'b0;
        burst_left = 0;
        while (coef_pending.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // Mix of special bins and random ones; some land outside the size.
    function automatic logic [11:0] pick_index(input logic [12:0] n);
        logic [12:0] half;
        half = n >> 1;
        case ($urandom_range(0, 9))
            0:       return 12'd0;
            1:       return 12'(half);
            2:       return 12'(half - 13'd1);
            3:       return 12'(half + 13'd1);
            4:       return 12'(n - 13'd1);
            5:       return 12'($urandom_range(0, 4095));
            default: return 12'($urandom_range(0, n - 1));
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Receiver: ready pattern changes mode after a random run of cycles
    // ---------------------------------------------------------------
    rx_mode_t rx_mode = RX_OPEN;
    int       rx_run  = 0;
    int       rx_tick = 0;

    always @(posedge i_clk) begin
        if (rx_run == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_run  = $urandom_range(10, 80);
        end
        rx_run--;
        rx_tick++;
        case (rx_mode)
            RX_OPEN:   i_m_tready <= 1'b1;
            RX_LIGHT:  i_m_tready <= ($urandom_range(0, 3) != 0);
            RX_HEAVY:  i_m_tready <= ($urandom_range(0, 3) == 0);
            default:   i_m_tready <= ((rx_tick % 7) < 4);
        endcase
    end

    // ---------------------------------------------------------------
    // Checker
    // ---------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("[%0t] MISMATCH %s: got %h, expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        bin_coef_t want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (coef_pending.size() == 0) begin
                report_mismatch("result with no request pending", o_m_tdata[63:0], '0);
            end else begin
                want = coef_pending.pop_front();
                if (o_m_tdata[63:0] !== want.re_part)
                    report_mismatch("coef_real", o_m_tdata[63:0], want.re_part);
                if (o_m_tdata[127:64] !== want.im_part)
                    report_mismatch("coef_imag", o_m_tdata[127:64], want.im_part);
                if (o_m_tuser !== want.ovf)
                    report_mismatch("overflow", 64'(o_m_tuser), 64'(want.ovf));
            end
        end
    end

    // ---------------------------------------------------------------
    // Watchdog: too long without any request moving on either side
    // ---------------------------------------------------------------
    int quiet_cycles = 0;

    initial begin
        while (quiet_cycles < WDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) quiet_cycles = 0;
            else quiet_cycles++;
        end
        $display("spectral_derivative_coefficient verification failed");
        $finish;
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    // Reset values: order_x 1, 256x256, unit steps.
    task automatic test_reset_settings();
        send_bin(12'd0, 12'd0);       // zero frequency, odd order
        send_bin(12'd1, 12'd0);
        send_bin(12'd128, 12'd0);     // Nyquist, odd order
        send_bin(12'd200, 12'd3);     // negative frequency
        send_bin(12'd255, 12'd255);
        send_bin(12'd256, 12'd0);     // row index past size
        send_bin(12'd0, 12'd4095);    // column index past size
        wait_for_results();
    endtask

    // Both orders zero: origin gives 1.0 in both parts, other bins in range a real 1.0, bins past the size zero.
    task automatic test_origin_zero_order();
        write_reg(CFG_ORDER_X, 32'd0);
        send_bin(12'd0, 12'd0);
        send_bin(12'd5, 12'd7);
        send_bin(12'd300, 12'd0);
        wait_for_results();
    endtask

    // Clamped order and size, largest steps: saturation to the negative full scale.
    task automatic test_saturation_extremes();
        write_all_regs(3'd7, 3'd2, 13'd8191, 13'd4097, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_bin(12'd2048, 12'd2048); // Nyquist on both axes, even orders
        send_bin(12'd4095, 12'd4095); // |f| = 1 on both axes, still saturates
        send_bin(12'd1, 12'd2049);
        wait_for_results();
    endtask

    // Odd orders: sign flips per axis with a negative frequency.
    task automatic test_odd_order_signs();
        write_all_regs(3'd3, 3'd1, 13'd5, 13'd9, 32'h0180_0000, 32'h0300_0000);
        send_bin(12'd3, 12'd7);
        send_bin(12'd1, 12'd5);
        send_bin(12'd3, 12'd1);
        send_bin(12'd2, 12'd1);       // Nyquist row, odd order
        send_bin(12'd0, 12'd3);       // zero row frequency
        wait_for_results();
        // smallest nonzero step: products round down to zero, no overflow
        write_reg(CFG_ROW_STEP, 32'd1);
        send_bin(12'd1, 12'd1);
        wait_for_results();
    endtask

    // Zero step, smallest size, and writes to unmapped indexes.
    task automatic test_zero_step_and_sizes();
        write_all_regs(3'd1, 3'd0, 13'd6, 13'd8, 32'd0, 32'h0100_0000);
        send_bin(12'd1, 12'd0);       // zero step kills the product
        wait_for_results();
        write_reg(CFG_ORDER_X, 32'd2);
        write_reg(CFG_ROWS, 32'd0);   // becomes 2
        write_reg(CFG_ROW_STEP, 32'h0200_0000);
        send_bin(12'd1, 12'd0);       // Nyquist, even order
        send_bin(12'd2, 12'd0);
        wait_for_results();
        write_reg(CFG_SPARE_A, 32'hFFFF_FFFF);
        write_reg(CFG_SPARE_B, 32'hFFFF_FFFF);
        send_bin(12'd1, 12'd0);       // settings must be unchanged
        wait_for_results();
    endtask

    // Random settings per phase, random bins; pipeline drained between phases.
    task automatic test_random_stream(input int total);
        int          sent;
        int          plen;
        logic [2:0]  ox, oy;
        logic [12:0] sz [2];
        logic [31:0] st [2];
        sent = 0;
        for (int phase = 0; sent < total; phase++) begin
            if (phase == 0) begin
                write_all_regs(3'd7, 3'd7, 13'd8191, 13'd8191, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
            end else if (phase == 1) begin
                write_all_regs(3'd0, 3'd0, 13'd0, 13'd0, 32'd0, 32'd0);
            end else begin
                ox = 3'($urandom_range(0, 7));
                oy = 3'($urandom_range(0, 7));
                for (int a = 0; a < 2; a++) begin
                    case ($urandom_range(0, 4))
                        0:       sz[a] = 13'($urandom_range(0, 8191));
                        1:       sz[a] = 13'd4096;
                        2:       sz[a] = 13'($urandom_range(2, 16));
                        default: sz[a] = 13'($urandom_range(2, 128));
                    endcase
                    case ($urandom_range(0, 5))
                        0:       st[a] = $urandom();
                        1:       st[a] = 32'd0;
                        2:       st[a] = 32'h0100_0000;
                        3:       st[a] = $urandom_range(0, 32'h0100_0000);
                        4:       st[a] = $urandom_range(1, 255);
                        default: st[a] = $urandom_range(0, 32'h0800_0000);
                    endcase
                end
                write_all_regs(ox, oy, sz[0], sz[1], st[0], st[1]);
            end
            plen = $urandom_range(60, 140);
            for (int k = 0; k < plen && sent < total; k++) begin
                send_bin(pick_index(legal_size(rows_reg)), pick_index(legal_size(cols_reg)));
                sent++;
            end
            wait_for_results();
        end
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        ord_x_reg    = ORDER_X_RST;
        ord_y_reg    = ORDER_Y_RST;
        rows_reg     = SIZE_RST;
        cols_reg     = SIZE_RST;
        row_step_reg = STEP_RST;
        col_step_reg = STEP_RST;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_settings();
        test_origin_zero_order();
        test_saturation_extremes();
        test_odd_order_signs();
        test_zero_step_and_sizes();
        test_random_stream(1130);

        wait_for_results();
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (coef_pending.size() != 0)
            report_mismatch("results never delivered", 64'(coef_pending.size()), '0);
        if (error_count == 0) begin
            $display("spectral_derivative_coefficient verification clean");
        end else begin
            $display("spectral_derivative_coefficient verification failed");
        end
        $finish;
    end

endmodule
